// ----- hw/rtl/msru_pkg.sv -----
package msru_pkg;

   localparam int ROWS_PER_PATTERN = 64;
   localparam int ROW_SLOTS        = 16;
   localparam int MASK_BITS        = 16;
   localparam int SLOT_W           = 4;
   localparam int ROW_W            = 6;
   localparam int PAT_W            = 8;
   localparam int BYTE_W           = 8;

   typedef enum logic [2:0] {
      PH_MASK_LO = 3'd0,
      PH_MASK_HI = 3'd1,
      PH_CELL0   = 3'd2,
      PH_CELL1   = 3'd3,
      PH_CELL2   = 3'd4,
      PH_CELL3   = 3'd5
   } msru_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              stream_end;
   } msru_item_type;

   typedef struct packed {
      logic              cell_valid;
      logic [ROW_W-1:0]  row_index;
      logic [SLOT_W-1:0] slot_index;
      logic [BYTE_W-1:0] note;
      logic [BYTE_W-1:0] instrument;
      logic [BYTE_W-1:0] effect;
      logic [BYTE_W-1:0] param;
      logic              pattern_done;
      logic [PAT_W-1:0]  pattern_index;
      logic              truncated;
   } msru_result_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } msru_scan_type;

   // Lowest slot at or after from whose mask bit is set; mask bit 15 is slot 0.
   function automatic msru_scan_type first_slot(input logic [MASK_BITS-1:0] mask,
                                                input logic [SLOT_W:0]      from);
      msru_scan_type r;
      r.found = 1'b0;
      r.slot  = '0;
      for (int s = MASK_BITS - 1; s >= 0; s--) begin
         if (mask[MASK_BITS - 1 - s] && ((SLOT_W + 1)'(s) >= from)) begin
            r.found = 1'b1;
            r.slot  = SLOT_W'(s);
         end
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/msru_in_stage.sv -----
module msru_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  msru_pkg::msru_item_type req_item,
   input  logic                   take,
   output logic                   item_valid,
   output msru_pkg::msru_item_type item
);

   logic                    valid_ff;
   logic                    valid_in;
   msru_pkg::msru_item_type item_ff;
   logic                    load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

   // a held byte that is not consumed must stay for the next cycle
   a_hold_unconsumed: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !take |=> valid_ff && item_ff == $past(item_ff))
      else $error("input stage dropped or changed an unconsumed byte");

endmodule

// ----- hw/rtl/msru_parser.sv -----
module msru_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  msru_pkg::msru_item_type   item,
   output logic                      emit,
   output msru_pkg::msru_result_type result
);

   msru_pkg::msru_phase_type          phase_ff, phase_in;
   logic [msru_pkg::MASK_BITS-1:0]    mask_ff, mask_in;
   logic [msru_pkg::SLOT_W-1:0]       scan_ff, scan_in;
   logic [msru_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [msru_pkg::PAT_W-1:0]        pattern_ff, pattern_in;
   logic [msru_pkg::BYTE_W-1:0]       note_ff, note_in;
   logic [msru_pkg::BYTE_W-1:0]       inst_ff, inst_in;
   logic [msru_pkg::BYTE_W-1:0]       eff_ff, eff_in;

   msru_pkg::msru_scan_type           head_scan;
   msru_pkg::msru_scan_type           next_scan;
   logic                              last_row;
   logic                              row_end;

   assign head_scan = msru_pkg::first_slot({item.data_byte, mask_ff[msru_pkg::BYTE_W-1:0]},
                                           '0);
   assign next_scan = msru_pkg::first_slot(mask_ff, {1'b0, scan_ff} + 1'b1);
   assign last_row  = ({1'b0, row_ff} + 1'b1) >= (msru_pkg::ROW_W + 1)'(msru_pkg::ROWS_PER_PATTERN);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= msru_pkg::PH_MASK_LO;
         mask_ff    <= '0;
         scan_ff    <= '0;
         row_ff     <= '0;
         pattern_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         mask_ff    <= mask_in;
         scan_ff    <= scan_in;
         row_ff     <= row_in;
         pattern_ff <= pattern_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
      inst_ff <= inst_in;
      eff_ff  <= eff_in;
   end

   always_comb begin
      phase_in   = phase_ff;
      mask_in    = mask_ff;
      scan_in    = scan_ff;
      row_in     = row_ff;
      pattern_in = pattern_ff;
      note_in    = note_ff;
      inst_in    = inst_ff;
      eff_in     = eff_ff;
      row_end    = 1'b0;
      emit       = 1'b0;

      result               = '0;
      result.row_index     = row_ff;
      result.pattern_index = pattern_ff;

      if (step) begin
         if (item.stream_end) begin
            if (row_ff != '0 || phase_ff != msru_pkg::PH_MASK_LO) begin
               phase_in         = msru_pkg::PH_MASK_LO;
               mask_in          = '0;
               scan_in          = '0;
               row_in           = '0;
               pattern_in       = '0;
               note_in          = '0;
               inst_in          = '0;
               eff_in           = '0;
               emit             = 1'b1;
               result.truncated = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               msru_pkg::PH_MASK_HI: begin
                  mask_in[msru_pkg::MASK_BITS-1:msru_pkg::BYTE_W] = item.data_byte;
                  if (head_scan.found) begin
                     scan_in  = head_scan.slot;
                     phase_in = msru_pkg::PH_CELL0;
                  end else begin
                     row_end = 1'b1;
                  end
               end
               msru_pkg::PH_CELL0: begin
                  note_in  = item.data_byte;
                  phase_in = msru_pkg::PH_CELL1;
               end
               msru_pkg::PH_CELL1: begin
                  inst_in  = item.data_byte;
                  phase_in = msru_pkg::PH_CELL2;
               end
               msru_pkg::PH_CELL2: begin
                  eff_in   = item.data_byte;
                  phase_in = msru_pkg::PH_CELL3;
               end
               msru_pkg::PH_CELL3: begin
                  if ({1'b0, scan_ff} < (msru_pkg::SLOT_W + 1)'(msru_pkg::ROW_SLOTS)) begin
                     emit              = 1'b1;
                     result.cell_valid = 1'b1;
                     result.slot_index = scan_ff;
                     result.note       = note_ff;
                     result.instrument = inst_ff;
                     result.effect     = eff_ff;
                     result.param      = item.data_byte;
                  end
                  note_in = '0;
                  inst_in = '0;
                  eff_in  = '0;
                  if (next_scan.found) begin
                     scan_in  = next_scan.slot;
                     phase_in = msru_pkg::PH_CELL0;
                  end else begin
                     row_end = 1'b1;
                  end
               end
               default: begin
                  mask_in  = {{msru_pkg::BYTE_W{1'b0}}, item.data_byte};
                  phase_in = msru_pkg::PH_MASK_HI;
               end
            endcase

            if (row_end) begin
               phase_in = msru_pkg::PH_MASK_LO;
               mask_in  = '0;
               scan_in  = '0;
               if (last_row) begin
                  row_in              = '0;
                  pattern_in          = pattern_ff + 1'b1;
                  emit                = 1'b1;
                  result.pattern_done = 1'b1;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
      end
   end

   a_cell_from_last_byte: assert property (@(posedge clock) disable iff (reset)
      emit && result.cell_valid |-> phase_ff == msru_pkg::PH_CELL3 && !item.stream_end)
      else $error("cell emitted outside the last cell byte");

   a_done_restarts_row: assert property (@(posedge clock) disable iff (reset)
      emit && result.pattern_done |=> phase_ff == msru_pkg::PH_MASK_LO && row_ff == '0)
      else $error("pattern end did not restart at row zero");

   a_trunc_clears: assert property (@(posedge clock) disable iff (reset)
      emit && result.truncated |=> pattern_ff == '0 && row_ff == '0
                                  && phase_ff == msru_pkg::PH_MASK_LO)
      else $error("truncation did not clear the parser");

endmodule

// ----- hw/rtl/msru_out_stage.sv -----
module msru_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  msru_pkg::msru_result_type result,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output msru_pkg::msru_result_type held
);

   logic                      valid_ff;
   logic                      valid_in;
   msru_pkg::msru_result_type result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign held       = result_ff;

   // a new result may only land once the previous one has left
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !valid_ff || rsp_tready)
      else $error("result register overwritten before transfer");

endmodule

// ----- hw/rtl/mask_sparse_row_unpacker_core.sv -----
// Path: a byte accepted into the input register produces its result, if any, in the result
//   register when it is taken from the input register.
// Throughput: one byte per cycle while the result side does not stall; the parser state updates once per byte.
// Reset: synchronous, active high; parser returns to the mask low byte, row and pattern
//   counters clear, and both the input and result registers empty.
module mask_sparse_row_unpacker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,  // [0] stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // [5:0] row_index, [9:6] slot_index, [17:10] note,
                                   // [25:18] instrument, [33:26] effect, [41:34] param,
                                   // [49:42] pattern_index, [55:50] zero
   output logic [1:0]  rsp_tuser,  // [0] cell_valid, [1] truncated
   output logic        rsp_tlast   // pattern_done
);

   msru_pkg::msru_item_type   req_item;
   msru_pkg::msru_item_type   item;
   logic                      item_valid;
   logic                      advance;
   logic                      emit;
   msru_pkg::msru_result_type result;
   msru_pkg::msru_result_type held;

   assign req_item.data_byte  = req_tdata;
   assign req_item.stream_end = req_tuser;

   // consume a byte whenever the result register can take what it produces
   assign advance = item_valid && (!rsp_tvalid || rsp_tready);

   msru_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   msru_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .emit   (emit),
      .result (result)
   );

   msru_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && emit),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .held       (held)
   );

   assign rsp_tdata = {6'b0, held.pattern_index, held.param, held.effect, held.instrument,
                       held.note, held.slot_index, held.row_index};
   assign rsp_tuser = {held.truncated, held.cell_valid};
   assign rsp_tlast = held.pattern_done;

endmodule
